@@ design/scrm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrm_pkg: shared types and constants of the running median filter
// Default sizes, field widths, rank register reset and comparator control.
// ----------------------------------------------------------------------------
package scrm_pkg;

    localparam int DEF_WINDOW      = 7;
    localparam int DEF_CHANNELS    = 6;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int FIELD_BITS = 16;
    localparam int RANK_BITS  = 3;

    localparam logic [RANK_BITS-1:0] RANK_RESET = 3'd3;

    typedef struct packed {
        logic load;
        logic cmp;
    } t_cmp_ctl;

endpackage

@@ design/scrm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module scrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 42
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/scrm_cmp_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrm_cmp_unit: shared signed comparator with rank counters
// Holds the candidate sample and counts window samples below and up to it.
// ----------------------------------------------------------------------------
module scrm_cmp_unit #(
    parameter int WINDOW      = scrm_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = scrm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  scrm_pkg::t_cmp_ctl               i_ctl,
    input  logic [SAMPLE_BITS-1:0]           i_data,
    output logic [SAMPLE_BITS-1:0]           o_cand,
    output logic [$clog2(WINDOW+1)-1:0]      o_lt_nxt,
    output logic [$clog2(WINDOW+1)-1:0]      o_le_nxt
);
    import scrm_pkg::*;

    localparam int CW = $clog2(WINDOW + 1);

    logic [SAMPLE_BITS-1:0] r_cand;
    logic [CW-1:0]          r_lt;
    logic [CW-1:0]          r_le;
    logic [CW-1:0]          n_lt;
    logic [CW-1:0]          n_le;
    logic                   less;
    logic                   equal;

    assign less  = $signed(i_data) < $signed(r_cand);
    assign equal = i_data == r_cand;

    always_comb begin
        n_lt = r_lt;
        n_le = r_le;
        if (i_ctl.load) begin
            n_lt = '0;
            n_le = '0;
        end else if (i_ctl.cmp) begin
            n_lt = r_lt + CW'(less);
            n_le = r_le + CW'(less | equal);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= '0;
            r_le <= '0;
        end else begin
            r_lt <= n_lt;
            r_le <= n_le;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cand <= i_data;
        end
    end

    assign o_cand   = r_cand;
    assign o_lt_nxt = n_lt;
    assign o_le_nxt = n_le;

    a_ctl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.load && i_ctl.cmp))
        else $error("load and compare in the same cycle");

    a_le_ge_lt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_le >= r_lt)
        else $error("up-to count below strict count");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_le <= CW'(WINDOW))
        else $error("count beyond window");

endmodule

@@ design/six_channel_running_median_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_channel_running_median_top: per-channel sliding-window rank filter
// Frames of CHANNELS angle samples in, one ranked value per channel out.
// ----------------------------------------------------------------------------
// After reset the window RAM is swept to zero, one entry a cycle, with
// s_axis_tready low. A frame then writes its CHANNELS samples in turn, and
// for each channel tries candidates one after another, each read and
// compared with every window sample, until the one at the selected rank is
// found (one to WINDOW candidates). The result is then handed over once the
// previous one has been taken, and the next frame is accepted after that.
// Ranking is serialised by the single read port of the window RAM feeding
// one shared comparator. A new frame is taken while the previous result
// still waits on the master side.
// ----------------------------------------------------------------------------
module six_channel_running_median_top #(
    parameter int WINDOW      = scrm_pkg::DEF_WINDOW,
    parameter int CHANNELS    = scrm_pkg::DEF_CHANNELS,
    parameter int SAMPLE_BITS = scrm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_wr_en,
    input  logic [scrm_pkg::RANK_BITS-1:0]              i_cfg_wr_data, // rank_select
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // angle_ch0 .. angle_chN, 16 bits each, from the lowest bit up
    input  logic [CHANNELS*scrm_pkg::FIELD_BITS-1:0]    s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // filtered_ch0 .. filtered_chN, 16 bits each, from the lowest bit up
    output logic [CHANNELS*scrm_pkg::FIELD_BITS-1:0]    m_axis_tdata
);
    import scrm_pkg::*;

    localparam int N   = CHANNELS * WINDOW;
    localparam int AW  = (N > 1) ? $clog2(N) : 1;
    localparam int SW  = $clog2(WINDOW);
    localparam int CW  = $clog2(WINDOW + 1);
    localparam int KW  = (CW > RANK_BITS) ? CW : RANK_BITS;
    localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DW  = CHANNELS * FIELD_BITS;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_RANK  = 3'd3;
    localparam logic [2:0] ST_LAST  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]             r_state,    n_state;
    logic [RANK_BITS-1:0]   r_rank;
    logic [SW-1:0]          r_slot,     n_slot;
    logic [CHW-1:0]         r_ch,       n_ch;
    logic [AW-1:0]          r_base,     n_base;
    logic [SW-1:0]          r_cand_idx, n_cand_idx;
    logic [CW-1:0]          r_step,     n_step;
    logic                   r_tag_load, n_tag_load;
    logic                   r_tag_cmp,  n_tag_cmp;
    logic                   r_ovalid,   n_ovalid;
    logic [DW-1:0]          r_in,       n_in;
    logic [DW-1:0]          r_res,      n_res;
    logic [DW-1:0]          r_odata,    n_odata;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [SAMPLE_BITS-1:0] wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;

    t_cmp_ctl               cmp_ctl;
    logic [SAMPLE_BITS-1:0] cand;
    logic [CW-1:0]          lt_nxt;
    logic [CW-1:0]          le_nxt;
    logic [KW-1:0]          rank_k;
    logic                   found;

    assign rank_k = (KW'(r_rank) > KW'(WINDOW - 1)) ? KW'(WINDOW - 1) : KW'(r_rank);
    assign found  = (KW'(lt_nxt) <= rank_k) && (KW'(le_nxt) > rank_k);

    assign cmp_ctl.load = r_tag_load;
    assign cmp_ctl.cmp  = r_tag_cmp;

    scrm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (N)
    ) u_window_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    scrm_cmp_unit #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cmp_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (cmp_ctl),
        .i_data   (rd_data),
        .o_cand   (cand),
        .o_lt_nxt (lt_nxt),
        .o_le_nxt (le_nxt)
    );

    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_ch       = r_ch;
        n_base     = r_base;
        n_cand_idx = r_cand_idx;
        n_step     = r_step;
        n_tag_load = 1'b0;
        n_tag_cmp  = 1'b0;
        n_in       = r_in;
        n_res      = r_res;
        n_odata    = r_odata;
        n_ovalid   = r_ovalid & ~m_axis_tready;
        wr_en      = 1'b0;
        wr_addr    = r_base;
        wr_data    = '0;
        rd_en      = 1'b0;
        rd_addr    = r_base;

        unique case (r_state)
            ST_CLEAR: begin
                wr_en = 1'b1;
                if (r_base == AW'(N - 1)) begin
                    n_base  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_base = r_base + AW'(1);
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_in    = s_axis_tdata;
                    n_ch    = '0;
                    n_base  = '0;
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                wr_en   = 1'b1;
                wr_addr = r_base + AW'(r_slot);
                wr_data = SAMPLE_BITS'($signed(r_in[FIELD_BITS-1:0]));
                n_in    = r_in >> FIELD_BITS;
                if (r_ch == CHW'(CHANNELS - 1)) begin
                    n_ch       = '0;
                    n_base     = '0;
                    n_slot     = (r_slot == SW'(WINDOW - 1)) ? '0 : r_slot + SW'(1);
                    n_cand_idx = '0;
                    n_step     = '0;
                    n_state    = ST_RANK;
                end else begin
                    n_ch   = r_ch + CHW'(1);
                    n_base = r_base + AW'(WINDOW);
                end
            end
            ST_RANK: begin
                rd_en      = 1'b1;
                rd_addr    = r_base + ((r_step == '0) ? AW'(r_cand_idx)
                                                      : AW'(r_step - CW'(1)));
                n_tag_load = (r_step == '0);
                n_tag_cmp  = (r_step != '0);
                if (r_step == CW'(WINDOW)) begin
                    n_state = ST_LAST;
                end else begin
                    n_step = r_step + CW'(1);
                end
            end
            ST_LAST: begin
                n_step = '0;
                if (found) begin
                    n_res[r_ch*FIELD_BITS +: FIELD_BITS] = FIELD_BITS'($signed(cand));
                    n_cand_idx = '0;
                    if (r_ch == CHW'(CHANNELS - 1)) begin
                        n_ch    = '0;
                        n_base  = '0;
                        n_state = ST_OUT;
                    end else begin
                        n_ch    = r_ch + CHW'(1);
                        n_base  = r_base + AW'(WINDOW);
                        n_state = ST_RANK;
                    end
                end else begin
                    n_cand_idx = r_cand_idx + SW'(1);
                    n_state    = ST_RANK;
                end
            end
            ST_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_odata  = r_res;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_base  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_rank     <= RANK_RESET;
            r_slot     <= '0;
            r_ch       <= '0;
            r_base     <= '0;
            r_cand_idx <= '0;
            r_step     <= '0;
            r_tag_load <= 1'b0;
            r_tag_cmp  <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_slot     <= n_slot;
            r_ch       <= n_ch;
            r_base     <= n_base;
            r_cand_idx <= n_cand_idx;
            r_step     <= n_step;
            r_tag_load <= n_tag_load;
            r_tag_cmp  <= n_tag_cmp;
            r_ovalid   <= n_ovalid;
            if (i_cfg_wr_en) begin
                r_rank <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_res   <= n_res;
        r_odata <= n_odata;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    a_last_cand_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LAST && r_cand_idx == SW'(WINDOW - 1)) |-> found)
        else $error("no window sample matched the selected rank");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SW'(WINDOW - 1))
        else $error("oldest slot beyond window");

    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ch <= CHW'(CHANNELS - 1))
        else $error("channel index beyond channel count");

    a_cmp_tag_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag_cmp |-> (r_state == ST_RANK || r_state == ST_LAST))
        else $error("compare data arriving outside ranking");

endmodule

@@ verif/tb_six_channel_running_median_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_six_channel_running_median_top: self-checking bench of the rank filter
// A table of directed frames walks the reset, extreme, saturated-rank and
// equal-sample behaviour. Random frames then follow, split into segments
// each with a new rank and one of three patterns of bus stalls. Each frame
// written to the block is passed through a behavioural sliding-window
// ranker. Every result transaction is compared per channel with the oldest pending expected frame.
// ----------------------------------------------------------------------------
module tb_six_channel_running_median_top;

    import scrm_pkg::*;

    localparam int CH         = DEF_CHANNELS;
    localparam int WIN        = DEF_WINDOW;
    localparam int CYCLE_CAP  = 4_000_000;
    localparam int TAIL_WAIT  = 400;
    localparam int SEG_FRAMES = 175;

    typedef logic [CH-1:0][FIELD_BITS-1:0] t_angle_frame;

    typedef struct {
        logic                 set_rank;
        logic [RANK_BITS-1:0] rank;
        t_angle_frame         angles;
        logic                 typed;
        t_angle_frame         filtered;
    } t_frame_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [RANK_BITS-1:0] i_cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    t_angle_frame         s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    t_angle_frame         m_axis_tdata;

    logic signed [FIELD_BITS-1:0] history [CH][WIN];
    int unsigned                  oldest_slot = 0;
    logic [RANK_BITS-1:0]         rank_now = RANK_RESET;

    t_angle_frame pending_ranked [$];
    t_frame_row   frame_table [$];
    t_angle_frame last_frame = '0;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;

    six_channel_running_median_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // angle_ch0 .. angle_ch5
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // filtered_ch0 .. filtered_ch5
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("six_channel_running_median_top test failed");
            $finish;
        end
    end

    initial begin
        for (int c = 0; c < CH; c++)
            for (int s = 0; s < WIN; s++)
                history[c][s] = '0;
    end

    function automatic t_angle_frame rank_windows(input t_angle_frame angles);
        t_angle_frame                 ranked;
        logic signed [FIELD_BITS-1:0] sorted [WIN];
        logic signed [FIELD_BITS-1:0] key;
        int                           pick;
        int                           j;
        pick = (rank_now > WIN - 1) ? WIN - 1 : int'(rank_now);
        for (int c = 0; c < CH; c++)
            history[c][oldest_slot] = angles[c];
        oldest_slot = (oldest_slot == WIN - 1) ? 0 : oldest_slot + 1;
        for (int c = 0; c < CH; c++) begin
            for (int s = 0; s < WIN; s++)
                sorted[s] = history[c][s];
            for (int i = 1; i < WIN; i++) begin
                key = sorted[i];
                for (j = i; j > 0 && sorted[j-1] > key; j--)
                    sorted[j] = sorted[j-1];
                sorted[j] = key;
            end
            ranked[c] = sorted[pick];
        end
        return ranked;
    endfunction

    function automatic t_angle_frame random_frame();
        t_angle_frame f;
        logic [FIELD_BITS-1:0] base;
        int kind;
        kind = $urandom_range(9);
        base = FIELD_BITS'($urandom);
        for (int c = 0; c < CH; c++) begin
            case (kind)
                5, 6: begin
                    f[c] = base + FIELD_BITS'($urandom_range(6)) - FIELD_BITS'(3);
                end
                7: begin
                    case ($urandom_range(4))
                        0: f[c] = 16'h8000;
                        1: f[c] = 16'h7FFF;
                        2: f[c] = 16'h0000;
                        3: f[c] = 16'hFFFF;
                        default: f[c] = 16'h0001;
                    endcase
                end
                8: begin
                    f[c] = last_frame[c];
                end
                9: begin
                    f[c] = base;
                end
                default: begin
                    f[c] = FIELD_BITS'($urandom);
                end
            endcase
        end
        return f;
    endfunction

    task automatic add_row(input logic set_rank, input logic [RANK_BITS-1:0] rank,
                           input t_angle_frame angles, input logic typed,
                           input t_angle_frame filtered);
        t_frame_row row;
        row.set_rank = set_rank;
        row.rank     = rank;
        row.angles   = angles;
        row.typed    = typed;
        row.filtered = filtered;
        frame_table = {frame_table, row};
    endtask

    task automatic send_frame(input t_angle_frame angles, input logic typed,
                              input t_angle_frame filtered);
        t_angle_frame predicted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= angles;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predicted = rank_windows(angles);
        last_frame = angles;
        pending_ranked = {pending_ranked, (typed ? filtered : predicted)};
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_ranked.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_rank(input logic [RANK_BITS-1:0] rank);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= rank;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        rank_now = rank;
    endtask

    always @(posedge i_clk) begin
        t_angle_frame want;
        if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            if (pending_ranked.size() == 0) begin
                $error("result transaction with no prediction pending: %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_ranked.pop_front();
                for (int c = 0; c < CH; c++) begin
                    if (m_axis_tdata[c] !== want[c]) begin
                        $error("filtered_ch%0d: expected %0d, actual %0d", c,
                               $signed(want[c]), $signed(m_axis_tdata[c]));
                        mismatch_count++;
                    end
                end
            end
        end
        if (recv_idle_pct == 0)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        t_angle_frame    eq_frame;
        logic [RANK_BITS-1:0] seg_rank [8];
        eq_frame = {16'hD300, 16'h2D00, 16'hFEAB, 16'h0155, 16'hF380, 16'h0C80};
        seg_rank = '{3'd0, 3'd6, 3'd7, 3'd3, 3'd1, 3'd5, 3'd2, 3'd4};

        // windows start from zero, so the median holds at zero for a while
        add_row(1'b0, 3'd0, {6{16'h7FFF}}, 1'b1, '0);
        add_row(1'b0, 3'd0, {6{16'h8000}}, 1'b1, '0);
        add_row(1'b0, 3'd0, {16'h0000, 16'h0040, 16'hFFC0, 16'h4000, 16'hFFFF, 16'h0001},
                1'b1, '0);
        add_row(1'b1, 3'd6, {16'hFF00, 16'h0100, 16'h8001, 16'h7FFE, 16'hEEEE, 16'h1111},
                1'b1, {6{16'h7FFF}});
        add_row(1'b1, 3'd0, {16'h0001, 16'hFFFE, 16'h2000, 16'hE000, 16'h7FFF, 16'h8000},
                1'b1, {6{16'h8000}});
        // rank above the window saturates to the largest sample
        add_row(1'b1, 3'd7, {6{16'h5555}}, 1'b1, {6{16'h7FFF}});
        add_row(1'b0, 3'd0, {6{16'hAAAA}}, 1'b1, {6{16'h7FFF}});
        add_row(1'b0, 3'd0, {16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00, 16'h3C3C, 16'hC3C3},
                1'b0, '0);
        add_row(1'b1, 3'd1, eq_frame, 1'b0, '0);
        for (int k = 0; k < 5; k++)
            add_row(1'b0, 3'd0, eq_frame, 1'b0, '0);
        // seven equal samples fill the window
        add_row(1'b0, 3'd0, eq_frame, 1'b1, eq_frame);
        add_row(1'b1, 3'd5, {6{16'hFFFF}}, 1'b0, '0);
        add_row(1'b1, 3'd2, {16'h1234, 16'hEDCB, 16'h0777, 16'hF889, 16'h4321, 16'hBCDF},
                1'b0, '0);
        add_row(1'b1, 3'd4, {16'h6000, 16'hA000, 16'h0010, 16'hFFF0, 16'h7FFF, 16'h8000},
                1'b0, '0);
        add_row(1'b1, 3'd3, {6{16'h0000}}, 1'b0, '0);

        send_idle_pct = 36;
        recv_idle_pct = 48;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (frame_table[r]) begin
            if (frame_table[r].set_rank) begin
                drain_results();
                write_rank(frame_table[r].rank);
            end
            send_frame(frame_table[r].angles, frame_table[r].typed, frame_table[r].filtered);
        end

        for (int seg = 0; seg < 8; seg++) begin
            drain_results();
            write_rank(seg_rank[seg]);
            if (seg < 3) begin
                send_idle_pct = 36;
                recv_idle_pct = 48;
            end else if (seg < 6) begin
                send_idle_pct = 48;
                recv_idle_pct = 36;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < SEG_FRAMES; n++)
                send_frame(random_frame(), 1'b0, '0);
        end

        drain_results();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && pending_ranked.size() == 0)
            $display("six_channel_running_median_top test passed");
        else
            $display("six_channel_running_median_top test failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/scrm_pkg.sv
design/scrm_ram.sv
design/scrm_cmp_unit.sv
design/six_channel_running_median_top.sv
verif/tb_six_channel_running_median_top.sv
